### src/bhpq_pkg.sv
// Package for the binary max-heap priority queue: widths, command and status
// codes, payload structs and sequencer state type. Depends on nothing.
package bhpq_pkg;

	localparam int HEAP_DEPTH = 256;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int SLOT_W     = ADDR_W + 1;
	localparam int KEY_W      = 32;
	localparam int TAG_W      = 8;
	localparam int CNT_W      = 9;

	localparam logic [CNT_W-1:0]        CAP_RESET    = CNT_W'(HEAP_DEPTH);
	localparam logic signed [KEY_W-1:0] SENTINEL_KEY = -32'sd32767;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_TOP_RD,
		ST_DN_RD,
		ST_DN_CMP,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		cmd_t                    command;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] top_key;
		logic [TAG_W-1:0]        top_tag;
		status_t                 status;
		logic [CNT_W-1:0]        entry_count;
	} result_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} entry_t;

	// Request from the port side into the sequencer
	typedef struct packed {
		logic             start;
		item_t            item;
		logic [CNT_W-1:0] cap;
	} seq_req_t;

	// Heap store access: one write, two registered reads, by slot (1-based)
	typedef struct packed {
		logic              wr_en;
		logic [SLOT_W-1:0] wr_slot;
		entry_t            wr_data;
		logic [SLOT_W-1:0] rd_a_slot;
		logic [SLOT_W-1:0] rd_b_slot;
	} mem_ctl_t;

endpackage

### src/bhpq_store.sv
// Heap entry memory: one write port and two read ports with registered data.
// Depends on bhpq_pkg. Slots are 1-based; slot s lives at address s-1.
module bhpq_store (
	input  logic               clk,
	input  bhpq_pkg::mem_ctl_t ctl,
	output bhpq_pkg::entry_t   rd_a_data,
	output bhpq_pkg::entry_t   rd_b_data
);

	bhpq_pkg::entry_t mem [bhpq_pkg::HEAP_DEPTH];

	logic [bhpq_pkg::SLOT_W-1:0] wr_off, rd_a_off, rd_b_off;

	// slot to address
	assign wr_off   = ctl.wr_slot - bhpq_pkg::SLOT_W'(1);
	assign rd_a_off = ctl.rd_a_slot - bhpq_pkg::SLOT_W'(1);
	assign rd_b_off = ctl.rd_b_slot - bhpq_pkg::SLOT_W'(1);

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_off[bhpq_pkg::ADDR_W-1:0]] <= ctl.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_data <= mem[rd_a_off[bhpq_pkg::ADDR_W-1:0]];
		rd_b_data <= mem[rd_b_off[bhpq_pkg::ADDR_W-1:0]];
	end

endmodule

### src/bhpq_seq.sv
// Heap sequencer: walks sift-up and sift-down one level at a time through
// key comparators, holding the moving entry in a register (hole method).
// Depends on bhpq_pkg and bhpq_store.
module bhpq_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bhpq_pkg::seq_req_t              req,
	input  logic                            take,
	output logic                            busy,
	output logic                            done,
	output bhpq_pkg::result_t               result
);

	bhpq_pkg::seq_state_t state_q, state_d;

	logic [bhpq_pkg::SLOT_W-1:0] pos_q;
	logic [bhpq_pkg::CNT_W-1:0]  cnt_q;
	bhpq_pkg::cmd_t              cmd_q;
	bhpq_pkg::entry_t            cur_q;
	logic signed [bhpq_pkg::KEY_W-1:0] res_key_q;
	logic [bhpq_pkg::TAG_W-1:0]  res_tag_q;
	bhpq_pkg::status_t           res_stat_q;

	bhpq_pkg::mem_ctl_t mem_ctl;
	bhpq_pkg::entry_t   rd_a_data, rd_b_data;

	logic [bhpq_pkg::CNT_W-1:0]  cap_eff;
	logic                        is_full, is_empty;
	logic [bhpq_pkg::SLOT_W:0]   left_x2, right_x2;
	logic                        has_left, has_right;
	logic [bhpq_pkg::SLOT_W-1:0] left_slot, right_slot, pick_slot;
	bhpq_pkg::entry_t            pick;
	logic                        pick_right;
	logic                        up_move, dn_move;

	bhpq_store u_store (
		.clk       (clk),
		.ctl       (mem_ctl),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	// effective capacity and occupancy flags
	assign cap_eff  = (req.cap > bhpq_pkg::CNT_W'(bhpq_pkg::HEAP_DEPTH)) ?
		bhpq_pkg::CNT_W'(bhpq_pkg::HEAP_DEPTH) : req.cap;
	assign is_full  = (cnt_q >= cap_eff);
	assign is_empty = (cnt_q == '0);

	// child slots of the hole
	assign left_x2    = {pos_q, 1'b0};
	assign right_x2   = {pos_q, 1'b1};
	assign has_left   = (left_x2 <= {1'b0, cnt_q});
	assign has_right  = (right_x2 <= {1'b0, cnt_q});
	assign left_slot  = left_x2[bhpq_pkg::SLOT_W-1:0];
	assign right_slot = right_x2[bhpq_pkg::SLOT_W-1:0];

	// comparators: left/right pick, then against the moving entry
	assign pick_right = has_right && (rd_a_data.key < rd_b_data.key);
	assign pick       = pick_right ? rd_b_data : rd_a_data;
	assign pick_slot  = pick_right ? right_slot : left_slot;
	assign up_move    = (rd_a_data.key < cur_q.key);
	assign dn_move    = !(pick.key < cur_q.key);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bhpq_pkg::ST_IDLE: begin
				if (req.start) begin
					unique case (req.item.command)
						bhpq_pkg::CMD_INSERT: state_d = is_full ? bhpq_pkg::ST_DONE
							: bhpq_pkg::ST_UP_RD;
						bhpq_pkg::CMD_REMOVE,
						bhpq_pkg::CMD_PEEK:   state_d = is_empty ? bhpq_pkg::ST_DONE
							: bhpq_pkg::ST_TOP_RD;
						default:              state_d = bhpq_pkg::ST_DONE;
					endcase
				end
			end
			bhpq_pkg::ST_UP_RD:  state_d = (pos_q == bhpq_pkg::SLOT_W'(1)) ?
				bhpq_pkg::ST_DONE : bhpq_pkg::ST_UP_CMP;
			bhpq_pkg::ST_UP_CMP: state_d = up_move ? bhpq_pkg::ST_UP_RD : bhpq_pkg::ST_DONE;
			bhpq_pkg::ST_TOP_RD: state_d = (cmd_q == bhpq_pkg::CMD_PEEK) ?
				bhpq_pkg::ST_DONE : bhpq_pkg::ST_DN_RD;
			bhpq_pkg::ST_DN_RD:  state_d = has_left ? bhpq_pkg::ST_DN_CMP : bhpq_pkg::ST_DONE;
			bhpq_pkg::ST_DN_CMP: state_d = dn_move ? bhpq_pkg::ST_DN_RD : bhpq_pkg::ST_DONE;
			bhpq_pkg::ST_DONE:   state_d = take ? bhpq_pkg::ST_IDLE : bhpq_pkg::ST_DONE;
			default:             state_d = bhpq_pkg::ST_IDLE;
		endcase
	end

	// memory controls and handshake outputs
	always_comb begin
		mem_ctl           = '0;
		mem_ctl.wr_data   = cur_q;
		mem_ctl.wr_slot   = pos_q;
		mem_ctl.rd_a_slot = bhpq_pkg::SLOT_W'(1);
		mem_ctl.rd_b_slot = cnt_q;
		busy              = (state_q != bhpq_pkg::ST_IDLE);
		done              = (state_q == bhpq_pkg::ST_DONE);
		unique case (state_q)
			bhpq_pkg::ST_UP_RD: begin
				mem_ctl.rd_a_slot = pos_q >> 1;
				mem_ctl.wr_en     = (pos_q == bhpq_pkg::SLOT_W'(1));
			end
			bhpq_pkg::ST_UP_CMP: begin
				mem_ctl.wr_en   = 1'b1;
				mem_ctl.wr_data = up_move ? rd_a_data : cur_q;
			end
			bhpq_pkg::ST_DN_RD: begin
				mem_ctl.rd_a_slot = left_slot;
				mem_ctl.rd_b_slot = right_slot;
				mem_ctl.wr_en     = !has_left;
			end
			bhpq_pkg::ST_DN_CMP: begin
				mem_ctl.wr_en   = 1'b1;
				mem_ctl.wr_data = dn_move ? pick : cur_q;
			end
			default: begin
				mem_ctl.wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhpq_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bhpq_pkg::ST_IDLE && req.start) begin
				unique case (req.item.command)
					bhpq_pkg::CMD_INSERT: if (!is_full) cnt_q <= cnt_q + 1'b1;
					bhpq_pkg::CMD_REMOVE: if (!is_empty) cnt_q <= cnt_q - 1'b1;
					bhpq_pkg::CMD_CLEAR:  cnt_q <= '0;
					default:              cnt_q <= cnt_q;
				endcase
			end
		end
	end

	// datapath registers: hole position, moving entry, result
	always_ff @(posedge clk) begin
		unique case (state_q)
			bhpq_pkg::ST_IDLE: begin
				cmd_q      <= req.item.command;
				cur_q      <= '{key: req.item.key, tag: req.item.tag};
				pos_q      <= cnt_q + 1'b1;
				res_key_q  <= '0;
				res_tag_q  <= '0;
				res_stat_q <= bhpq_pkg::STAT_DONE;
				if (req.item.command == bhpq_pkg::CMD_INSERT && is_full) begin
					res_stat_q <= bhpq_pkg::STAT_FULL;
				end
				if ((req.item.command == bhpq_pkg::CMD_REMOVE ||
					req.item.command == bhpq_pkg::CMD_PEEK) && is_empty) begin
					res_key_q  <= bhpq_pkg::SENTINEL_KEY;
					res_stat_q <= bhpq_pkg::STAT_EMPTY;
				end
			end
			bhpq_pkg::ST_UP_CMP: begin
				if (up_move) pos_q <= pos_q >> 1;
			end
			bhpq_pkg::ST_TOP_RD: begin
				res_key_q <= rd_a_data.key;
				res_tag_q <= rd_a_data.tag;
				cur_q     <= rd_b_data;
				pos_q     <= bhpq_pkg::SLOT_W'(1);
			end
			bhpq_pkg::ST_DN_CMP: begin
				if (dn_move) pos_q <= pick_slot;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign result = '{top_key: res_key_q, top_tag: res_tag_q, status: res_stat_q,
		entry_count: cnt_q};

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bhpq_pkg::CNT_W'(bhpq_pkg::HEAP_DEPTH))
		else $error("occupancy above heap depth");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == bhpq_pkg::ST_IDLE)
		else $error("start while busy");
	a_up_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bhpq_pkg::ST_UP_CMP |-> pos_q >= bhpq_pkg::SLOT_W'(2))
		else $error("sift-up compare at root");
	a_wr_slot: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr_en |-> (mem_ctl.wr_slot != '0 &&
			mem_ctl.wr_slot <= bhpq_pkg::SLOT_W'(bhpq_pkg::HEAP_DEPTH)))
		else $error("heap write outside slots");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done && !take |=> done && $stable(result))
		else $error("result changed while waiting");

endmodule

### src/binary_max_heap_priority_queue_unit.sv
// Top level of the binary max-heap priority queue: ports, capacity register,
// result output register. Depends on bhpq_pkg and bhpq_seq.
//
//  channel | direction | handshake          | payload
//  cmd     | in        | cmd_valid/cmd_stall | cmd_item  (item_t)
//  res     | out       | res_valid/res_stall | res_item  (result_t)
//  cfg     | in        | cfg_valid/cfg_ready | cfg_data  (capacity, 9 bits)
//
// One command at a time. Clear, refused or empty commands go straight to done,
// peek reads the root and stops, insert climbs level by level from the new
// last slot, remove reads the root and the last entry and then descends level by
// level; a level is one store read and one compare/write.
// Reset clears the count and sets capacity to 256, not the heap contents.
// A finished result waits in the output register while the next is taken.
module binary_max_heap_priority_queue_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  bhpq_pkg::item_t                 cmd_item,
	output logic                            res_valid,
	input  logic                            res_stall,
	output bhpq_pkg::result_t               res_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bhpq_pkg::CNT_W-1:0]      cfg_data
);

	logic [bhpq_pkg::CNT_W-1:0] cap_q;
	logic                       res_valid_q;
	bhpq_pkg::result_t          res_q;
	bhpq_pkg::seq_req_t         req;
	bhpq_pkg::result_t          seq_result;
	logic                       seq_busy, seq_done, take;

	// capacity register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bhpq_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// command transfer starts the sequencer
	assign cmd_stall = seq_busy;
	assign req       = '{start: cmd_valid && !seq_busy, item: cmd_item, cap: cap_q};

	bhpq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (take),
		.busy   (seq_busy),
		.done   (seq_done),
		.result (seq_result)
	);

	// output register: load when empty or being drained
	assign take = seq_done && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= seq_result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

### verif/bhpq_heap_checker.sv
`timescale 1ns / 100ps
// Checker for the binary max-heap priority queue. It mirrors the heap and the
// capacity register from the transfers it sees and checks every result.
// Depends on bhpq_pkg.
module bhpq_heap_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  logic                       cmd_stall,
	input  bhpq_pkg::item_t            cmd_item,
	input  logic                       res_valid,
	input  logic                       res_stall,
	input  bhpq_pkg::result_t          res_item,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [bhpq_pkg::CNT_W-1:0] cfg_data,
	output int                         owed_count,
	output int                         mismatch_count
);

	// Mirror of the heap (root at slot 1), its fill level and the capacity
	bhpq_pkg::entry_t           heap_slots [1:bhpq_pkg::HEAP_DEPTH];
	int                         heap_fill;
	logic [bhpq_pkg::CNT_W-1:0] cap_reg;
	bhpq_pkg::result_t          owed_results [$];

	function automatic void swap_slots(int a, int b);
		bhpq_pkg::entry_t held;
		held          = heap_slots[a];
		heap_slots[a] = heap_slots[b];
		heap_slots[b] = held;
	endfunction

	// Apply one command to the mirror and return the result it must produce
	function automatic bhpq_pkg::result_t apply_heap_command(bhpq_pkg::item_t it);
		bhpq_pkg::result_t r;
		int                limit;
		int                pos;
		int                pick;
		r.top_key = '0;
		r.top_tag = '0;
		r.status  = bhpq_pkg::STAT_DONE;
		// capacity above the store size is clipped to it
		limit = (cap_reg < bhpq_pkg::HEAP_DEPTH) ? int'(cap_reg) : bhpq_pkg::HEAP_DEPTH;
		case (it.command)
			bhpq_pkg::CMD_INSERT: begin
				if (heap_fill >= limit) begin
					r.status = bhpq_pkg::STAT_FULL;
				end else begin
					heap_fill++;
					heap_slots[heap_fill].key = it.key;
					heap_slots[heap_fill].tag = it.tag;
					// climb while the parent is strictly smaller
					pos = heap_fill;
					while (pos > 1 &&
					       $signed(heap_slots[pos / 2].key) < $signed(heap_slots[pos].key)) begin
						swap_slots(pos / 2, pos);
						pos = pos / 2;
					end
				end
			end
			bhpq_pkg::CMD_REMOVE: begin
				if (heap_fill == 0) begin
					r.top_key = bhpq_pkg::SENTINEL_KEY;
					r.status  = bhpq_pkg::STAT_EMPTY;
				end else begin
					r.top_key     = heap_slots[1].key;
					r.top_tag     = heap_slots[1].tag;
					heap_slots[1] = heap_slots[heap_fill];
					heap_fill--;
					// descend toward the larger child, left wins ties, equal child swaps
					pos = 1;
					while (2 * pos <= heap_fill) begin
						pick = 2 * pos;
						if (pick + 1 <= heap_fill &&
						    $signed(heap_slots[pick].key) < $signed(heap_slots[pick + 1].key))
							pick = pick + 1;
						if ($signed(heap_slots[pick].key) < $signed(heap_slots[pos].key))
							break;
						swap_slots(pos, pick);
						pos = pick;
					end
				end
			end
			bhpq_pkg::CMD_PEEK: begin
				if (heap_fill == 0) begin
					r.top_key = bhpq_pkg::SENTINEL_KEY;
					r.status  = bhpq_pkg::STAT_EMPTY;
				end else begin
					r.top_key = heap_slots[1].key;
					r.top_tag = heap_slots[1].tag;
				end
			end
			bhpq_pkg::CMD_CLEAR: begin
				heap_fill = 0;
			end
		endcase
		r.entry_count = bhpq_pkg::CNT_W'(heap_fill);
		return r;
	endfunction

	// Track transfers: results are checked before the same edge's command is queued
	always @(posedge clk or negedge arst_n) begin
		bhpq_pkg::result_t want;
		int                delta;
		int                fails;
		if (!arst_n) begin
			heap_fill = 0;
			cap_reg   = bhpq_pkg::CAP_RESET;
			owed_results.delete();
			owed_count     <= 0;
			mismatch_count <= 0;
		end else begin
			delta = 0;
			fails = 0;
			if (cfg_valid && cfg_ready)
				cap_reg = cfg_data;
			if (res_valid && !res_stall) begin
				if (owed_results.size() == 0) begin
					$error("unexpected result transfer: top_key %0d, status %0d",
					       $signed(res_item.top_key), res_item.status);
					fails++;
				end else begin
					want = owed_results.pop_front();
					delta--;
					if (res_item.top_key !== want.top_key) begin
						$error("top_key: expected %0d, actual %0d",
						       $signed(want.top_key), $signed(res_item.top_key));
						fails++;
					end
					if (res_item.top_tag !== want.top_tag) begin
						$error("top_tag: expected %0d, actual %0d", want.top_tag, res_item.top_tag);
						fails++;
					end
					if (res_item.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, res_item.status);
						fails++;
					end
					if (res_item.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, actual %0d",
						       want.entry_count, res_item.entry_count);
						fails++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				owed_results.push_back(apply_heap_command(cmd_item));
				delta++;
			end
			owed_count     <= owed_count + delta;
			mismatch_count <= mismatch_count + fails;
		end
	end

endmodule

### verif/tb_binary_max_heap_priority_queue_unit.sv
`timescale 1ns / 100ps
// Testbench top for binary_max_heap_priority_queue_unit: clock, reset, command
// and capacity stimulus, result-side stalls and the verdict.
// Depends on bhpq_pkg, the block and bhpq_heap_checker.
module tb_binary_max_heap_priority_queue_unit;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int SETTLE_CYCLES   = 40;

	localparam logic signed [bhpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [bhpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

	logic                       clk;
	logic                       arst_n;
	logic                       cmd_valid;
	logic                       cmd_stall;
	bhpq_pkg::item_t            cmd_item;
	logic                       res_valid;
	logic                       res_stall;
	bhpq_pkg::result_t          res_item;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [bhpq_pkg::CNT_W-1:0] cfg_data;
	int                         owed_count;
	int                         mismatch_count;
	bit                         idling_on;
	bit                         hold_off_req;

	binary_max_heap_priority_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	bhpq_heap_checker heap_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.cmd_item       (cmd_item),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.res_item       (res_item),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.owed_count     (owed_count),
		.mismatch_count (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Mostly random keys, with small ranges for ties and the extremes
	function automatic logic signed [bhpq_pkg::KEY_W-1:0] rand_key();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return $urandom;
		if (sel < 7)
			return bhpq_pkg::KEY_W'(int'($urandom_range(0, 15)) - 8);
		if (sel < 9)
			return bhpq_pkg::KEY_W'(int'($urandom_range(0, 2000)) - 1000);
		case ($urandom_range(0, 4))
			0: return KEY_MAX;
			1: return KEY_MIN;
			2: return bhpq_pkg::SENTINEL_KEY;
			3: return '1;
			default: return '0;
		endcase
	endfunction

	function automatic logic [bhpq_pkg::TAG_W-1:0] rand_tag();
		return bhpq_pkg::TAG_W'($urandom_range(0, 255));
	endfunction

	// One command transfer, with an optional idle burst ahead of it
	task automatic push_command(bhpq_pkg::cmd_t c, logic signed [bhpq_pkg::KEY_W-1:0] k,
		logic [bhpq_pkg::TAG_W-1:0] t);
		bhpq_pkg::item_t it;
		int              gap;
		it.command = c;
		it.key     = k;
		it.tag     = t;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= it;
		do @(posedge clk); while (cmd_stall);
	endtask

	// Stop sending and wait until every owed result has come back
	task automatic drain_queue();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (owed_count != 0);
	endtask

	task automatic set_capacity(logic [bhpq_pkg::CNT_W-1:0] v);
		drain_queue();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_mix(int count, int ins_pct, int rem_pct, int peek_pct);
		int             roll;
		bhpq_pkg::cmd_t c;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				c = bhpq_pkg::CMD_INSERT;
			else if (roll < ins_pct + rem_pct)
				c = bhpq_pkg::CMD_REMOVE;
			else if (roll < ins_pct + rem_pct + peek_pct)
				c = bhpq_pkg::CMD_PEEK;
			else
				c = bhpq_pkg::CMD_CLEAR;
			push_command(c, rand_key(), rand_tag());
		end
	endtask

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin
		int burst;
		bit hold_off_done;
		hold_off_done = 1'b0;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 9);
				res_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		cmd_valid    <= 1'b0;
		cmd_item     <= '0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		idling_on    = 1'b1;
		hold_off_req = 1'b0;
		@(posedge arst_n);
		@(posedge clk);

		// empty queue, extreme keys and tags, tie order, clear
		push_command(bhpq_pkg::CMD_PEEK, KEY_MAX, 8'hFF);
		push_command(bhpq_pkg::CMD_REMOVE, KEY_MIN, 8'h00);
		push_command(bhpq_pkg::CMD_INSERT, KEY_MAX, 8'hFF);
		push_command(bhpq_pkg::CMD_INSERT, KEY_MIN, 8'h00);
		push_command(bhpq_pkg::CMD_INSERT, bhpq_pkg::SENTINEL_KEY, 8'h5A);
		push_command(bhpq_pkg::CMD_INSERT, 32'sd5, 8'd1);
		push_command(bhpq_pkg::CMD_INSERT, 32'sd5, 8'd2);
		push_command(bhpq_pkg::CMD_INSERT, 32'sd5, 8'd3);
		push_command(bhpq_pkg::CMD_PEEK, '0, '0);
		repeat (4) push_command(bhpq_pkg::CMD_REMOVE, '0, '0);
		push_command(bhpq_pkg::CMD_CLEAR, '1, 8'hA5);
		push_command(bhpq_pkg::CMD_PEEK, '0, '0);

		// zero capacity refuses every insert, capacity one holds a single entry
		set_capacity('0);
		push_command(bhpq_pkg::CMD_INSERT, 32'sd7, 8'd7);
		set_capacity(9'd1);
		push_command(bhpq_pkg::CMD_INSERT, -32'sd3, 8'd9);
		push_command(bhpq_pkg::CMD_INSERT, 32'sd4, 8'd10);
		push_command(bhpq_pkg::CMD_REMOVE, '0, '0);

		// capacity lowered below the fill level
		set_capacity(9'd256);
		repeat (3) push_command(bhpq_pkg::CMD_INSERT, rand_key(), rand_tag());
		set_capacity(9'd2);
		push_command(bhpq_pkg::CMD_INSERT, 32'sd1, 8'd1);
		push_command(bhpq_pkg::CMD_REMOVE, '0, '0);
		push_command(bhpq_pkg::CMD_REMOVE, '0, '0);
		push_command(bhpq_pkg::CMD_INSERT, 32'sd2, 8'd2);

		// mixed traffic, with a long result hold-off in the middle
		set_capacity(9'd256);
		run_mix(150, 60, 30, 8);
		hold_off_req = 1'b1;
		run_mix(250, 55, 35, 8);

		// fill past the store size with capacity above it, then empty it out
		set_capacity(9'd511);
		repeat (258) push_command(bhpq_pkg::CMD_INSERT, rand_key(), rand_tag());
		repeat (4) push_command(bhpq_pkg::CMD_PEEK, rand_key(), rand_tag());
		repeat (262) push_command(bhpq_pkg::CMD_REMOVE, rand_key(), rand_tag());

		// small random capacities
		repeat (6) begin
			set_capacity(bhpq_pkg::CNT_W'($urandom_range(2, 20)));
			run_mix(50, 50, 40, 8);
		end
		set_capacity(9'd1);
		run_mix(60, 45, 35, 15);

		// shrink the capacity under a well-filled heap
		set_capacity(9'd256);
		repeat (30) push_command(bhpq_pkg::CMD_INSERT, rand_key(), rand_tag());
		set_capacity(9'd10);
		run_mix(60, 50, 40, 8);

		// last stretch at full rate
		set_capacity(9'd256);
		idling_on = 1'b0;
		run_mix(300, 55, 35, 8);

		drain_queue();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && owed_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
